@@ src/zzp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_pkg
// Shared widths, codes and record types of the zigzag pivot tracker.
// ----------------------------------------------------------------------------
package zzp_pkg;

	localparam int TIME_BITS  = 48;
	localparam int LEVEL_BITS = 32;

	// result queue: room for two results beyond any one item's pair
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [TIME_BITS-1:0]  tstamp_t;
	typedef logic [LEVEL_BITS-1:0] level_t;

	// input action codes
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// result event codes
	localparam logic EV_MOVE   = 1'b0;
	localparam logic EV_APPEND = 1'b1;

	typedef struct packed {
		logic    kind;
		tstamp_t ptime;
		level_t  plevel;
		logic    is_high;
		logic    last;
	} res_t;

	// results of one item handed to the queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

@@ src/zzp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_core
// Seed and pivot state with the per-item update; produces up to two results.
// ----------------------------------------------------------------------------
module zzp_core import zzp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    act,
	input  tstamp_t t_in,
	input  level_t  l_in,
	input  level_t  thr,
	output push_t   push
);

	tstamp_t lo_t_q, hi_t_q, piv_t_q;
	level_t  lo_l_q, hi_l_q, piv_l_q;
	logic    started_q, piv_high_q;

	tstamp_t lo_t_d, hi_t_d, piv_t_d;
	level_t  lo_l_d, hi_l_d, piv_l_d;
	logic    started_d, piv_high_d;
	push_t   push_d;

	// compute next state and the results of the current item
	always_comb begin
		lo_t_d     = lo_t_q;
		lo_l_d     = lo_l_q;
		hi_t_d     = hi_t_q;
		hi_l_d     = hi_l_q;
		piv_t_d    = piv_t_q;
		piv_l_d    = piv_l_q;
		started_d  = started_q;
		piv_high_d = piv_high_q;
		push_d     = '0;
		if (act == ACT_CLEAR) begin
			lo_t_d     = '0;
			lo_l_d     = '0;
			hi_t_d     = '0;
			hi_l_d     = '0;
			piv_t_d    = '0;
			piv_l_d    = '0;
			started_d  = 1'b0;
			piv_high_d = 1'b0;
		end else if (!started_q) begin
			// seed unset slots, then track extremes
			if (lo_t_q == '0) begin
				lo_t_d = t_in;
				lo_l_d = l_in;
			end
			if (hi_t_q == '0) begin
				hi_t_d = t_in;
				hi_l_d = l_in;
			end
			if (l_in > hi_l_d) begin
				hi_t_d = t_in;
				hi_l_d = l_in;
			end
			if (l_in < lo_l_d) begin
				lo_t_d = t_in;
				lo_l_d = l_in;
			end
			if (hi_l_d >= lo_l_d && (hi_l_d - lo_l_d) >= thr) begin
				if (hi_t_d < lo_t_d) begin
					push_d.n  = 2'd2;
					push_d.r0 = '{EV_APPEND, hi_t_d, hi_l_d, 1'b1, 1'b0};
					push_d.r1 = '{EV_APPEND, lo_t_d, lo_l_d, 1'b0, 1'b1};
					started_d  = 1'b1;
					piv_t_d    = lo_t_d;
					piv_l_d    = lo_l_d;
					piv_high_d = 1'b0;
				end else if (lo_t_d < hi_t_d) begin
					push_d.n  = 2'd2;
					push_d.r0 = '{EV_APPEND, lo_t_d, lo_l_d, 1'b0, 1'b0};
					push_d.r1 = '{EV_APPEND, hi_t_d, hi_l_d, 1'b1, 1'b1};
					started_d  = 1'b1;
					piv_t_d    = hi_t_d;
					piv_l_d    = hi_l_d;
					piv_high_d = 1'b1;
				end
			end
		end else if (piv_high_q) begin
			// last pivot is a high: extend it or reverse down
			if (l_in > piv_l_q) begin
				piv_t_d   = t_in;
				piv_l_d   = l_in;
				push_d.n  = 2'd1;
				push_d.r0 = '{EV_MOVE, t_in, l_in, 1'b1, 1'b1};
			end else if ((piv_l_q - l_in) >= thr) begin
				piv_t_d    = t_in;
				piv_l_d    = l_in;
				piv_high_d = 1'b0;
				push_d.n   = 2'd1;
				push_d.r0  = '{EV_APPEND, t_in, l_in, 1'b0, 1'b1};
			end
		end else begin
			// last pivot is a low: extend it or reverse up
			if (l_in < piv_l_q) begin
				piv_t_d   = t_in;
				piv_l_d   = l_in;
				push_d.n  = 2'd1;
				push_d.r0 = '{EV_MOVE, t_in, l_in, 1'b0, 1'b1};
			end else if ((l_in - piv_l_q) >= thr) begin
				piv_t_d    = t_in;
				piv_l_d    = l_in;
				piv_high_d = 1'b1;
				push_d.n   = 2'd1;
				push_d.r0  = '{EV_APPEND, t_in, l_in, 1'b1, 1'b1};
			end
		end
	end

	// hand results to the queue only when an item fires
	always_comb begin
		push = push_d;
		if (!fire) begin
			push.n = 2'd0;
		end
	end

	// hold state, advance on each fired item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_t_q     <= '0;
			lo_l_q     <= '0;
			hi_t_q     <= '0;
			hi_l_q     <= '0;
			piv_t_q    <= '0;
			piv_l_q    <= '0;
			started_q  <= 1'b0;
			piv_high_q <= 1'b0;
		end else if (fire) begin
			lo_t_q     <= lo_t_d;
			lo_l_q     <= lo_l_d;
			hi_t_q     <= hi_t_d;
			hi_l_q     <= hi_l_d;
			piv_t_q    <= piv_t_d;
			piv_l_q    <= piv_l_d;
			started_q  <= started_d;
			piv_high_q <= piv_high_d;
		end
	end

endmodule

@@ src/zzp_res_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_res_fifo
// Result queue: takes up to two results per cycle, presents one per request.
// ----------------------------------------------------------------------------
module zzp_res_fifo import zzp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	res_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_ptr_p1;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign head      = mem[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + FIFO_PTR_W'(1);

	// write the pair of results
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_p1] <= push.r1;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

@@ src/zigzag_pivot_tracker.sv @@
`timescale 1ns / 1ps
// A request waits in the input register until the queue has room; its results
// are then written into the result queue, whose head drives the output.
// Throughput: one request per cycle while the queue has room; an item that starts
// the pivots gives two results, which leave one per request while input keeps flowing into a queue.
// Input stalls only while more than two results wait in the queue.
// Reset clears seeds, pivots and the queue, and sets the threshold to one.
// ----------------------------------------------------------------------------
// zigzag_pivot_tracker
// Zigzag swing-pivot tracker with a configurable reversal threshold.
// ----------------------------------------------------------------------------
module zigzag_pivot_tracker import zzp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  level_t  cfg_wdata,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    action,
	input  tstamp_t sample_time,
	input  level_t  sample_level,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    event_kind,
	output tstamp_t pivot_time,
	output level_t  pivot_level,
	output logic    pivot_is_high,
	output logic    last_of_run
);

	level_t  thr_q;
	logic    valid_s1;
	logic    act_s1;
	tstamp_t time_s1;
	level_t  level_s1;
	logic    room;
	logic    fire;
	push_t   push;
	res_t    head;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= level_t'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// input register: hold until the core takes the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1   <= action;
			time_s1  <= sample_time;
			level_s1 <= sample_level;
		end
	end

	zzp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.act    (act_s1),
		.t_in   (time_s1),
		.l_in   (level_s1),
		.thr    (thr_q),
		.push   (push)
	);

	zzp_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// drive result fields from the queue head
	assign event_kind    = head.kind;
	assign pivot_time    = head.ptime;
	assign pivot_level   = head.plevel;
	assign pivot_is_high = head.is_high;
	assign last_of_run   = head.last;

endmodule

@@ src/zzp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_checker
// Port-level checks of the zigzag pivot tracker, bound to the top level.
// ----------------------------------------------------------------------------
module zzp_checker import zzp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input logic    event_kind,
	input tstamp_t pivot_time,
	input logic    last_of_run
);

	// hold a stalled result request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pivot_time))
		else $error("stalled result dropped or changed");

	// a moved pivot always closes its run
	a_move_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_MOVE |-> last_of_run)
		else $error("pivot move not marked last of run");

	// only the first of a start pair stays open
	a_open_append: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> event_kind == EV_APPEND)
		else $error("open run on a non-append result");

	// input stalls only while results are pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind zigzag_pivot_tracker zzp_checker u_zzp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.event_kind  (event_kind),
	.pivot_time  (pivot_time),
	.last_of_run (last_of_run)
);

@@ verif/zigzag_pivot_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_pivot_tracker_tb
// Self-checking bench for the zigzag pivot tracker. A scoreboard keeps its
// own copy of the seeds, the last pivot and the threshold. It predicts the
// pivot reports for every accepted request and checks each report in order.
// Directed swings come first. Random swings follow under several thresholds,
// with random gaps on both channels, one long output stall and a full drain
// before each threshold write.
// ----------------------------------------------------------------------------
module zigzag_pivot_tracker_tb;
	import zzp_pkg::*;

	localparam int     TOP_GAP  = 6;
	localparam int     HOLD_CYC = 80;
	localparam level_t LEVEL_MAX = '1;
	localparam tstamp_t TIME_MAX = '1;

	// Predict pivot reports and check them against the block
	class pivot_scoreboard;
		level_t  threshold;
		tstamp_t lo_t, hi_t, piv_t;
		level_t  lo_l, hi_l, piv_l;
		bit      started, piv_high;
		res_t    expected_pivots[$];
		int      mismatch_count;

		function new();
			threshold = 1;
			mismatch_count = 0;
			clear_swing();
		endfunction

		function void clear_swing();
			lo_t = '0; lo_l = '0; hi_t = '0; hi_l = '0;
			started = 0; piv_t = '0; piv_l = '0; piv_high = 0;
		endfunction

		function void set_threshold(level_t v);
			threshold = v;
		endfunction

		// Append one predicted report at the tail
		function void queue_pivot(res_t r);
			expected_pivots = {expected_pivots, r};
		endfunction

		function void note_sample(logic act, tstamp_t t, level_t l);
			if (act == ACT_CLEAR) begin
				clear_swing();
				return;
			end
			// Track seeds until the first pair of pivots is confirmed
			if (!started) begin
				if (lo_t == '0) begin
					lo_t = t; lo_l = l;
				end
				if (hi_t == '0) begin
					hi_t = t; hi_l = l;
				end
				if (l > hi_l) begin
					hi_t = t; hi_l = l;
				end
				if (l < lo_l) begin
					lo_t = t; lo_l = l;
				end
				if (hi_l >= lo_l && level_t'(hi_l - lo_l) >= threshold && hi_t != lo_t) begin
					if (hi_t < lo_t) begin
						queue_pivot('{EV_APPEND, hi_t, hi_l, 1'b1, 1'b0});
						queue_pivot('{EV_APPEND, lo_t, lo_l, 1'b0, 1'b1});
						piv_t = lo_t; piv_l = lo_l; piv_high = 0;
					end else begin
						queue_pivot('{EV_APPEND, lo_t, lo_l, 1'b0, 1'b0});
						queue_pivot('{EV_APPEND, hi_t, hi_l, 1'b1, 1'b1});
						piv_t = hi_t; piv_l = hi_l; piv_high = 1;
					end
					started = 1;
				end
			end else if (piv_high) begin
				// Extend the swing high, or reverse down by the threshold
				if (l > piv_l) begin
					piv_t = t; piv_l = l;
					queue_pivot('{EV_MOVE, t, l, 1'b1, 1'b1});
				end else if (level_t'(piv_l - l) >= threshold) begin
					piv_t = t; piv_l = l; piv_high = 0;
					queue_pivot('{EV_APPEND, t, l, 1'b0, 1'b1});
				end
			end else begin
				// Extend the swing low, or reverse up by the threshold
				if (l < piv_l) begin
					piv_t = t; piv_l = l;
					queue_pivot('{EV_MOVE, t, l, 1'b0, 1'b1});
				end else if (level_t'(l - piv_l) >= threshold) begin
					piv_t = t; piv_l = l; piv_high = 1;
					queue_pivot('{EV_APPEND, t, l, 1'b1, 1'b1});
				end
			end
		endfunction

		function void check_pivot(res_t got);
			res_t want;
			if (expected_pivots.size() == 0) begin
				$error("unexpected pivot report: time %0h level %0h", got.ptime, got.plevel);
				mismatch_count++;
				return;
			end
			want = expected_pivots.pop_front();
			if (got.kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, got.kind);
				mismatch_count++;
			end
			if (got.ptime !== want.ptime) begin
				$error("pivot_time: expected %0h, got %0h", want.ptime, got.ptime);
				mismatch_count++;
			end
			if (got.plevel !== want.plevel) begin
				$error("pivot_level: expected %0h, got %0h", want.plevel, got.plevel);
				mismatch_count++;
			end
			if (got.is_high !== want.is_high) begin
				$error("pivot_is_high: expected %0d, got %0d", want.is_high, got.is_high);
				mismatch_count++;
			end
			if (got.last !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, got.last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_we = 1'b0;
	level_t  cfg_wdata = '0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	logic    action = ACT_PUSH;
	tstamp_t sample_time = '0;
	level_t  sample_level = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	logic    event_kind;
	tstamp_t pivot_time;
	level_t  pivot_level;
	logic    pivot_is_high;
	logic    last_of_run;

	pivot_scoreboard sb = new();
	bit      calm = 0;
	bit      hold_req = 0;
	tstamp_t cur_time = 48'd100;
	level_t  cur_level = 32'd1000;

	zigzag_pivot_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.sample_time   (sample_time),
		.sample_level  (sample_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.pivot_time    (pivot_time),
		.pivot_level   (pivot_level),
		.pivot_is_high (pivot_is_high),
		.last_of_run   (last_of_run)
	);

	always #2 clk = ~clk;

	// Offer one request after a random gap and hold it until accepted
	task automatic push_sample(logic act, tstamp_t t, level_t l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, TOP_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		sample_time  <= t;
		sample_level <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(act, t, l);
	endtask

	// Drop input and wait until every pivot report has come out
	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (sb.expected_pivots.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_threshold(level_t v);
		settle_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(v);
	endtask

	// Random swings around the threshold, with some clears and odd timestamps
	task automatic run_swings(int count, int quiet);
		int      k, pick;
		longint  span, lv;
		logic    act;
		tstamp_t t;
		level_t  l;
		span = (sb.threshold < 4) ? 8 :
			(sb.threshold > 32'h2000_0000) ? 64'h4000_0000 : longint'(sb.threshold) * 2;
		for (k = 0; k < count; k++) begin
			calm = (k < quiet);
			act = ($urandom_range(0, 99) < 3) ? ACT_CLEAR : ACT_PUSH;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				t = '0;
			end else if (pick < 9) begin
				cur_time = tstamp_t'({$urandom, $urandom});
				t = cur_time;
			end else begin
				cur_time = cur_time + $urandom_range(1, 40);
				t = cur_time;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				l = $urandom_range(0, 1) ? LEVEL_MAX : '0;
			end else if (pick < 20) begin
				l = $urandom;
			end else begin
				lv = longint'(cur_level) + longint'($urandom_range(0, 32'(2 * span))) - span;
				if (lv < 0) lv = 0;
				if (lv > longint'(LEVEL_MAX)) lv = longint'(LEVEL_MAX);
				l = level_t'(lv);
			end
			cur_level = l;
			push_sample(act, t, l);
		end
		calm = 0;
	endtask

	// Accept pivot reports, stalling at random or for a long hold
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_pivot('{event_kind, pivot_time, pivot_level, pivot_is_high, last_of_run});
				stall_left = calm ? 0 : $urandom_range(0, TOP_GAP);
			end
			if (hold_req) begin
				hold_left = HOLD_CYC;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Threshold one from reset: time zero seeds a slot that stays unset
		push_sample(ACT_PUSH, 48'd0, 32'd5);
		push_sample(ACT_PUSH, 48'd10, 32'd5);
		push_sample(ACT_PUSH, 48'd0, 32'd9);
		push_sample(ACT_CLEAR, TIME_MAX, LEVEL_MAX);
		// Both seeds on one timestamp emit nothing until one moves
		push_sample(ACT_PUSH, 48'd7, 32'd0);
		push_sample(ACT_PUSH, 48'd7, 32'd100);
		push_sample(ACT_PUSH, 48'd8, 32'd50);
		push_sample(ACT_PUSH, 48'd9, 32'd200);
		// Extend, equal level, reverse, and the level extremes
		push_sample(ACT_PUSH, 48'd10, 32'd300);
		push_sample(ACT_PUSH, 48'd11, 32'd300);
		push_sample(ACT_PUSH, 48'd12, 32'd299);
		push_sample(ACT_PUSH, 48'd13, 32'd0);
		push_sample(ACT_PUSH, 48'd14, LEVEL_MAX);
		push_sample(ACT_PUSH, TIME_MAX, LEVEL_MAX);
		push_sample(ACT_PUSH, TIME_MAX, 32'd0);
		push_sample(ACT_CLEAR, 48'd0, 32'd0);
		// High seed before low seed
		push_sample(ACT_PUSH, 48'd20, 32'd50);
		push_sample(ACT_PUSH, 48'd21, 32'd40);
		push_sample(ACT_PUSH, 48'd22, 32'd39);
		push_sample(ACT_PUSH, 48'd23, 32'd40);
		run_swings(75, 20);

		// Threshold zero: an equal level reverses; every push after the start reports
		apply_threshold(32'd0);
		push_sample(ACT_CLEAR, 48'd0, 32'd0);
		push_sample(ACT_PUSH, 48'd30, 32'd10);
		push_sample(ACT_PUSH, 48'd31, 32'd20);
		push_sample(ACT_PUSH, 48'd32, 32'd20);
		hold_req = 1;
		run_swings(75, 30);

		// Full-scale threshold needs the whole level range
		apply_threshold(LEVEL_MAX);
		push_sample(ACT_CLEAR, 48'd0, 32'd0);
		push_sample(ACT_PUSH, 48'd1, 32'd0);
		push_sample(ACT_PUSH, 48'd2, LEVEL_MAX);
		push_sample(ACT_PUSH, 48'd3, 32'd0);
		run_swings(75, 0);

		apply_threshold(32'd37);
		run_swings(75, 15);

		apply_threshold($urandom);
		run_swings(75, 0);

		apply_threshold(32'd1);
		run_swings(75, 25);

		settle_pipeline();
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/zzp_pkg.sv
src/zzp_core.sv
src/zzp_res_fifo.sv
src/zigzag_pivot_tracker.sv
src/zzp_checker.sv
verif/zigzag_pivot_tracker_tb.sv
